/* sv/owb_pkg.sv */
// Shared types, constants and the CRC8 step for the 1-Wire bus master.
package owb_pkg;

  localparam int CFG_W = 10;

  localparam logic [CFG_W-1:0] READ_SAMPLE_TICKS = 10'd20;
  localparam logic [CFG_W-1:0] READ_TAIL_TICKS   = 10'd45;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_ticks;
    logic [CFG_W-1:0] presence_wait_ticks;
    logic [CFG_W-1:0] reset_tail_ticks;
    logic [CFG_W-1:0] write_one_low_ticks;
    logic [CFG_W-1:0] write_one_high_ticks;
    logic [CFG_W-1:0] write_zero_low_ticks;
    logic [CFG_W-1:0] write_zero_high_ticks;
    logic [CFG_W-1:0] read_low_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       line_level;
    logic       crc_clear;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic [7:0] crc_value;
    logic       crc_zero;
    logic       rejected;
  } result_t;

  // Dallas/Maxim CRC8, reflected, one byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* sv/one_wire_bus_master.sv */
// Top level of the 1-Wire bus master: input stage, sequencer and result stage.
// Each beat on the input channel is either a one-microsecond tick carrying the
// sampled bus level or a reset, write-byte or read-byte command; each produces
// exactly one result beat. An item passes from the input register to the result
// register through the single state update with its tick compare and byte-wide
// CRC8 step, and a new item is taken every clock unless a stalled output holds
// a result, so throughput is one item per cycle. The input stage only stalls
// while a result is held by a stalled output. Timing registers are to be written
// over the APB port while the bus is idle; the block itself does not enforce this.
module one_wire_bus_master #(
  parameter int COUNTER_WIDTH = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic        line_level,
  input  logic        crc_clear,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        drive_low,
  output logic        busy_res,
  output logic        done_res,
  output logic        presence,
  output logic [7:0]  read_byte,
  output logic [7:0]  crc_value,
  output logic        crc_zero,
  output logic        rejected,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  owb_pkg::cfg_t    cfg;
  owb_pkg::item_t   in_item;
  logic             in_held;
  owb_pkg::result_t res_comb;
  owb_pkg::result_t res;
  logic             advance;
  logic             take;

  assign advance  = in_held && (!out_valid || !out_stall);
  assign in_stall = in_held && !advance;
  assign take     = in_valid && !in_stall;

  owb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owb_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (take) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item.kind       <= kind;
      in_item.data_byte  <= data_byte;
      in_item.line_level <= line_level;
      in_item.crc_clear  <= crc_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign drive_low = res.drive_low;
  assign busy_res  = res.busy_res;
  assign done_res  = res.done_res;
  assign presence  = res.presence;
  assign read_byte = res.read_byte;
  assign crc_value = res.crc_value;
  assign crc_zero  = res.crc_zero;
  assign rejected  = res.rejected;

  // the line is only pulled low inside a running operation
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_low |-> busy_res && !done_res)
    else $error("drive low outside an operation");

  // a completing beat is never busy and never a rejection
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !rejected)
    else $error("done beat flagged busy or rejected");

  // crc flag follows the crc value
  a_crc_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> crc_zero == (crc_value == 8'h00))
    else $error("crc flag mismatch");

endmodule

/* sv/owb_regs.sv */
// APB timing register file of the 1-Wire bus master.
module owb_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output owb_pkg::cfg_t       cfg
);

  localparam logic [2:0] REG_RESET_LOW    = 3'd0;
  localparam logic [2:0] REG_PRESENCE     = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL   = 3'd2;
  localparam logic [2:0] REG_WR1_LOW      = 3'd3;
  localparam logic [2:0] REG_WR1_HIGH     = 3'd4;
  localparam logic [2:0] REG_WR0_LOW      = 3'd5;
  localparam logic [2:0] REG_WR0_HIGH     = 3'd6;
  localparam logic [2:0] REG_READ_LOW     = 3'd7;

  logic [2:0]                  index;
  logic                        wr_en;
  logic [owb_pkg::CFG_W-1:0]   wdata;
  logic [owb_pkg::CFG_W-1:0]   rdata;

  assign pready = 1'b1;
  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign wdata  = pwdata[owb_pkg::CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks       <= 10'd480;
      cfg.presence_wait_ticks   <= 10'd65;
      cfg.reset_tail_ticks      <= 10'd405;
      cfg.write_one_low_ticks   <= 10'd1;
      cfg.write_one_high_ticks  <= 10'd60;
      cfg.write_zero_low_ticks  <= 10'd60;
      cfg.write_zero_high_ticks <= 10'd10;
      cfg.read_low_ticks        <= 10'd2;
    end else if (wr_en) begin
      unique case (index)
        REG_RESET_LOW:  cfg.reset_low_ticks       <= wdata;
        REG_PRESENCE:   cfg.presence_wait_ticks   <= wdata;
        REG_RESET_TAIL: cfg.reset_tail_ticks      <= wdata;
        REG_WR1_LOW:    cfg.write_one_low_ticks   <= wdata;
        REG_WR1_HIGH:   cfg.write_one_high_ticks  <= wdata;
        REG_WR0_LOW:    cfg.write_zero_low_ticks  <= wdata;
        REG_WR0_HIGH:   cfg.write_zero_high_ticks <= wdata;
        REG_READ_LOW:   cfg.read_low_ticks        <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_RESET_LOW:  rdata = cfg.reset_low_ticks;
      REG_PRESENCE:   rdata = cfg.presence_wait_ticks;
      REG_RESET_TAIL: rdata = cfg.reset_tail_ticks;
      REG_WR1_LOW:    rdata = cfg.write_one_low_ticks;
      REG_WR1_HIGH:   rdata = cfg.write_one_high_ticks;
      REG_WR0_LOW:    rdata = cfg.write_zero_low_ticks;
      REG_WR0_HIGH:   rdata = cfg.write_zero_high_ticks;
      REG_READ_LOW:   rdata = cfg.read_low_ticks;
      default:        rdata = '0;
    endcase
  end

  assign prdata = 32'(rdata);

endmodule

/* sv/owb_engine.sv */
// Bus sequencing state, tick counter, shifter and CRC of the 1-Wire bus master.
module owb_engine #(
  parameter int COUNTER_WIDTH = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  owb_pkg::item_t    item,
  input  owb_pkg::cfg_t     cfg,
  output owb_pkg::result_t  result
);

  localparam int CMP_W = (COUNTER_WIDTH > owb_pkg::CFG_W) ? COUNTER_WIDTH : owb_pkg::CFG_W;
  localparam logic [CMP_W-1:0]         CNT_MAX   = CMP_W'((1 << COUNTER_WIDTH) - 1);
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX_C = '1;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_RST_LOW   = 3'd1;
  localparam logic [2:0] PH_RST_WAIT  = 3'd2;
  localparam logic [2:0] PH_RST_TAIL  = 3'd3;
  localparam logic [2:0] PH_SLOT_LOW  = 3'd4;
  localparam logic [2:0] PH_SLOT_HIGH = 3'd5;
  localparam logic [2:0] PH_READ_TAIL = 3'd6;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  logic [2:0]               phase, phase_next;
  logic [1:0]               operation, operation_next;
  logic [COUNTER_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]               bit_index, bit_index_next;
  logic [7:0]               shift_byte, shift_byte_next;
  logic [7:0]               crc_accum, crc_accum_next;
  logic                     presence_flag, presence_flag_next;
  logic [7:0]               last_read, last_read_next;

  logic [owb_pkg::CFG_W-1:0] raw_len;
  logic [CMP_W-1:0]          len;
  logic [COUNTER_WIDTH-1:0]  tick_inc;
  logic                      done, rej;

  function automatic logic [CMP_W-1:0] clip_len(input logic [owb_pkg::CFG_W-1:0] d);
    logic [CMP_W-1:0] w;
    w = CMP_W'(d);
    if (w == '0) begin
      w = CMP_W'(1);
    end
    if (w > CNT_MAX) begin
      w = CNT_MAX;
    end
    return w;
  endfunction

  always_comb begin
    unique case (phase)
      PH_RST_LOW:   raw_len = cfg.reset_low_ticks;
      PH_RST_WAIT:  raw_len = cfg.presence_wait_ticks;
      PH_RST_TAIL:  raw_len = cfg.reset_tail_ticks;
      PH_SLOT_LOW: begin
        if (operation == OP_READ) begin
          raw_len = cfg.read_low_ticks;
        end else begin
          raw_len = shift_byte[0] ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks;
        end
      end
      PH_SLOT_HIGH: begin
        if (operation == OP_READ) begin
          raw_len = owb_pkg::READ_SAMPLE_TICKS;
        end else begin
          raw_len = shift_byte[0] ? cfg.write_one_high_ticks : cfg.write_zero_high_ticks;
        end
      end
      default:      raw_len = owb_pkg::READ_TAIL_TICKS;
    endcase
  end

  assign len      = clip_len(raw_len);
  assign tick_inc = (tick_count != CNT_MAX_C) ? tick_count + 1'b1 : tick_count;

  always_comb begin
    phase_next         = phase;
    operation_next     = operation;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    crc_accum_next     = crc_accum;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    done               = 1'b0;
    rej                = 1'b0;

    if (item.kind != OP_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        if (item.crc_clear) begin
          crc_accum_next = '0;
        end
        operation_next  = item.kind;
        tick_count_next = '0;
        bit_index_next  = '0;
        if (item.kind == OP_RESET) begin
          phase_next = PH_RST_LOW;
        end else begin
          shift_byte_next = (item.kind == OP_WRITE) ? item.data_byte : 8'h00;
          phase_next      = PH_SLOT_LOW;
        end
      end
    end else if (phase != PH_IDLE) begin
      tick_count_next = tick_inc;
      if (CMP_W'(tick_inc) >= len) begin
        tick_count_next = '0;
        unique case (phase) inside
          PH_RST_LOW:  phase_next = PH_RST_WAIT;
          PH_RST_WAIT: begin
            presence_flag_next = !item.line_level;
            phase_next         = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            phase_next     = PH_IDLE;
            operation_next = OP_TICK;
            done           = 1'b1;
          end
          PH_SLOT_LOW: phase_next = PH_SLOT_HIGH;
          PH_SLOT_HIGH, PH_READ_TAIL: begin
            if (phase == PH_SLOT_HIGH && operation == OP_READ) begin
              if (item.line_level) begin
                shift_byte_next[bit_index] = 1'b1;
              end
              phase_next = PH_READ_TAIL;
            end else begin
              if (phase == PH_SLOT_HIGH) begin
                shift_byte_next = shift_byte >> 1;
              end
              if (bit_index == 3'd7) begin
                if (operation == OP_READ) begin
                  last_read_next = shift_byte;
                  crc_accum_next = owb_pkg::crc8_step(crc_accum, shift_byte);
                end
                phase_next     = PH_IDLE;
                operation_next = OP_TICK;
                bit_index_next = '0;
                done           = 1'b1;
              end else begin
                bit_index_next = bit_index + 1'b1;
                phase_next     = PH_SLOT_LOW;
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= OP_TICK;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      crc_accum     <= '0;
      presence_flag <= 1'b0;
      last_read     <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      operation     <= operation_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      crc_accum     <= crc_accum_next;
      presence_flag <= presence_flag_next;
      last_read     <= last_read_next;
    end
  end

  assign result.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
  assign result.busy_res  = (phase_next != PH_IDLE);
  assign result.done_res  = done;
  assign result.presence  = presence_flag_next;
  assign result.read_byte = last_read_next;
  assign result.crc_value = crc_accum_next;
  assign result.crc_zero  = (crc_accum_next == 8'h00);
  assign result.rejected  = rej;

  // idle leaves no counter or bit position behind
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0 && bit_index == '0)
    else $error("idle with live counters");

  // a rejected command leaves the sequence untouched
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    fire && rej |=> $stable(phase) && $stable(crc_accum) && $stable(shift_byte))
    else $error("rejected command changed state");

  // a finished operation returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    fire && done |=> phase == PH_IDLE && operation == OP_TICK)
    else $error("done without returning to idle");

endmodule

/* tb/one_wire_bus_master_tb.sv */
// Self-checking testbench for the 1-Wire bus master: timed bus operations, CRC and refusals.
`timescale 1ns / 1ps

module one_wire_bus_master_tb;

  typedef enum logic [1:0] {K_TICK, K_RESET, K_WRITE, K_READ} kind_e;
  typedef enum logic [2:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_SLOT_LOW, PH_SLOT_HIGH, PH_READ_TAIL
  } bus_phase_e;
  typedef enum int {
    R_RST_LOW, R_PRES_WAIT, R_RST_TAIL, R_W1_LOW, R_W1_HIGH, R_W0_LOW, R_W0_HIGH, R_RD_LOW,
    R_COUNT
  } reg_e;
  typedef enum int {TM_MIN, TM_ZERO, TM_SMALL, TM_MIXED, TM_MAX} timing_e;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [9:0] CNT_TOP = 10'h3FF;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = K_TICK;
  logic [7:0]  data_byte = 8'h00;
  logic        line_level = 1'b1;
  logic        crc_clear = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        drive_low, busy_res, done_res, presence, crc_zero, rejected;
  logic [7:0]  read_byte, crc_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  one_wire_bus_master u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .data_byte(data_byte), .line_level(line_level), .crc_clear(crc_clear),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_low(drive_low), .busy_res(busy_res), .done_res(done_res), .presence(presence),
    .read_byte(read_byte), .crc_value(crc_value), .crc_zero(crc_zero), .rejected(rejected),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  owb_pkg::item_t   cmd_q[$];
  owb_pkg::item_t   op_q[$];
  owb_pkg::result_t status_q[$];

  int errors = 0;
  int n_beats = 0;
  int n_done = 0;
  int n_refused = 0;
  int n_reads = 0;
  int n_good = 0;
  int n_settings = 0;
  int quiet = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit in_fire = 1'b0;

  // bus master shadow state
  owb_pkg::cfg_t bus_cfg;
  bus_phase_e    bus_phase;
  logic [1:0]    bus_op;
  logic [9:0]    tick_cnt;
  logic [2:0]    bit_pos;
  logic [7:0]    shreg;
  logic [7:0]    crc_run;
  logic          presence_q;
  logic [7:0]    last_byte;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[7:1]};
      if (fb) c = c ^ 8'h8C;
    end
    return c;
  endfunction

  function automatic logic [9:0] span(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic [9:0] get_reg(input int idx);
    case (idx)
      R_RST_LOW:   return bus_cfg.reset_low_ticks;
      R_PRES_WAIT: return bus_cfg.presence_wait_ticks;
      R_RST_TAIL:  return bus_cfg.reset_tail_ticks;
      R_W1_LOW:    return bus_cfg.write_one_low_ticks;
      R_W1_HIGH:   return bus_cfg.write_one_high_ticks;
      R_W0_LOW:    return bus_cfg.write_zero_low_ticks;
      R_W0_HIGH:   return bus_cfg.write_zero_high_ticks;
      default:     return bus_cfg.read_low_ticks;
    endcase
  endfunction

  task automatic put_reg(input int idx, input logic [9:0] v);
    case (idx)
      R_RST_LOW:   bus_cfg.reset_low_ticks = v;
      R_PRES_WAIT: bus_cfg.presence_wait_ticks = v;
      R_RST_TAIL:  bus_cfg.reset_tail_ticks = v;
      R_W1_LOW:    bus_cfg.write_one_low_ticks = v;
      R_W1_HIGH:   bus_cfg.write_one_high_ticks = v;
      R_W0_LOW:    bus_cfg.write_zero_low_ticks = v;
      R_W0_HIGH:   bus_cfg.write_zero_high_ticks = v;
      default:     bus_cfg.read_low_ticks = v;
    endcase
  endtask

  task automatic bus_reset();
    bus_cfg.reset_low_ticks       = 10'd480;
    bus_cfg.presence_wait_ticks   = 10'd65;
    bus_cfg.reset_tail_ticks      = 10'd405;
    bus_cfg.write_one_low_ticks   = 10'd1;
    bus_cfg.write_one_high_ticks  = 10'd60;
    bus_cfg.write_zero_low_ticks  = 10'd60;
    bus_cfg.write_zero_high_ticks = 10'd10;
    bus_cfg.read_low_ticks        = 10'd2;
    bus_phase  = PH_IDLE;
    bus_op     = OP_NONE;
    tick_cnt   = 10'd0;
    bit_pos    = 3'd0;
    shreg      = 8'h00;
    crc_run    = 8'h00;
    presence_q = 1'b0;
    last_byte  = 8'h00;
  endtask

  function automatic logic [9:0] slot_len();
    case (bus_phase)
      PH_RST_LOW:  return span(bus_cfg.reset_low_ticks);
      PH_RST_WAIT: return span(bus_cfg.presence_wait_ticks);
      PH_RST_TAIL: return span(bus_cfg.reset_tail_ticks);
      PH_SLOT_LOW: begin
        if (bus_op == K_READ) return span(bus_cfg.read_low_ticks);
        return span(shreg[0] ? bus_cfg.write_one_low_ticks : bus_cfg.write_zero_low_ticks);
      end
      PH_SLOT_HIGH: begin
        if (bus_op == K_READ) return span(owb_pkg::READ_SAMPLE_TICKS);
        return span(shreg[0] ? bus_cfg.write_one_high_ticks : bus_cfg.write_zero_high_ticks);
      end
      default: return span(owb_pkg::READ_TAIL_TICKS);
    endcase
  endfunction

  task automatic close_bit(output logic fin);
    if (bit_pos == 3'd7) begin
      if (bus_op == K_READ) begin
        last_byte = shreg;
        crc_run = crc_feed(crc_run, shreg);
        n_reads++;
        if (crc_run == 8'h00) n_good++;
      end
      bus_phase = PH_IDLE;
      bus_op = OP_NONE;
      bit_pos = 3'd0;
      fin = 1'b1;
    end else begin
      bit_pos++;
      bus_phase = PH_SLOT_LOW;
      fin = 1'b0;
    end
  endtask

  task automatic advance_bus(input owb_pkg::item_t it, output owb_pkg::result_t r);
    logic fin;
    logic refused;
    fin = 1'b0;
    refused = 1'b0;
    if (it.kind != K_TICK) begin
      if (bus_phase != PH_IDLE) begin
        refused = 1'b1;
      end else begin
        if (it.crc_clear) crc_run = 8'h00;
        bus_op = it.kind;
        tick_cnt = 10'd0;
        bit_pos = 3'd0;
        if (it.kind == K_RESET) begin
          bus_phase = PH_RST_LOW;
        end else begin
          shreg = (it.kind == K_WRITE) ? it.data_byte : 8'h00;
          bus_phase = PH_SLOT_LOW;
        end
      end
    end else if (bus_phase != PH_IDLE) begin
      if (tick_cnt != CNT_TOP) tick_cnt++;
      if (tick_cnt >= slot_len()) begin
        tick_cnt = 10'd0;
        case (bus_phase)
          PH_RST_LOW: bus_phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            presence_q = ~it.line_level;
            bus_phase = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            bus_phase = PH_IDLE;
            bus_op = OP_NONE;
            fin = 1'b1;
          end
          PH_SLOT_LOW: bus_phase = PH_SLOT_HIGH;
          PH_SLOT_HIGH: begin
            if (bus_op == K_READ) begin
              if (it.line_level) shreg[bit_pos] = 1'b1;
              bus_phase = PH_READ_TAIL;
            end else begin
              shreg = shreg >> 1;
              close_bit(fin);
            end
          end
          default: close_bit(fin);
        endcase
      end
    end
    r.drive_low = (bus_phase == PH_RST_LOW) || (bus_phase == PH_SLOT_LOW);
    r.busy_res  = (bus_phase != PH_IDLE);
    r.done_res  = fin;
    r.presence  = presence_q;
    r.read_byte = last_byte;
    r.crc_value = crc_run;
    r.crc_zero  = (crc_run == 8'h00);
    r.rejected  = refused;
    if (fin) n_done++;
    if (refused) n_refused++;
  endtask

  function automatic string show(input owb_pkg::result_t r);
    return $sformatf("drv=%b busy=%b done=%b pres=%b rd=%02h crc=%02h zero=%b rej=%b",
                     r.drive_low, r.busy_res, r.done_res, r.presence, r.read_byte,
                     r.crc_value, r.crc_zero, r.rejected);
  endfunction

  // result check and prediction, sampled at the rising edge
  always @(posedge clk) begin : mon
    owb_pkg::result_t want;
    owb_pkg::result_t got;
    owb_pkg::item_t   it;
    bit               out_fire;
    if (rst) begin
      in_fire = 1'b0;
      quiet = 0;
      bus_reset();
    end else begin
      in_fire = in_valid && !in_stall;
      out_fire = out_valid && !out_stall;
      if (out_fire) begin
        got.drive_low = drive_low;
        got.busy_res  = busy_res;
        got.done_res  = done_res;
        got.presence  = presence;
        got.read_byte = read_byte;
        got.crc_value = crc_value;
        got.crc_zero  = crc_zero;
        got.rejected  = rejected;
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %s", show(got));
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("beat %0d mismatch\n  exp %s\n  got %s", n_beats - status_q.size() - 1,
                       show(want), show(got));
          end
        end
      end
      if (in_fire) begin
        it.kind = kind;
        it.data_byte = data_byte;
        it.line_level = line_level;
        it.crc_clear = crc_clear;
        advance_bus(it, want);
        status_q.push_back(want);
        n_beats++;
      end
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", quiet);
        $display("one_wire_bus_master_tb NOT OK");
        $finish;
      end
    end
  end

  // input driver and output stall, driven at the falling edge
  always @(negedge clk) begin : drv
    owb_pkg::item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
          gap_left = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          it = cmd_q.pop_front();
          kind <= it.kind;
          data_byte <= it.data_byte;
          line_level <= it.line_level;
          crc_clear <= it.crc_clear;
          in_valid <= 1'b1;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 14) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_item(input logic [1:0] k, input logic [7:0] d, input logic lvl,
                          input logic clr);
    owb_pkg::item_t it;
    it.kind = k;
    it.data_byte = d;
    it.line_level = lvl;
    it.crc_clear = clr;
    op_q.push_back(it);
  endtask

  // ticks of one phase; the last one carries the level that gets sampled
  task automatic add_ticks(input int n, input logic last_lvl, input int odds);
    for (int i = 0; i < n; i++) begin
      if (odds > 0 && $urandom_range(1, odds) == 1)
        add_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      add_item(K_TICK, 8'($urandom_range(0, 255)),
               (i == n - 1) ? last_lvl : 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // command plus the ticks it needs; bits gives read data or presence in bit 0
  task automatic plan_op(input logic [1:0] k, input logic [7:0] d, input logic clr,
                         input logic [7:0] bits, input int odds);
    logic b;
    add_item(k, d, 1'($urandom_range(0, 1)), clr);
    case (k)
      K_RESET: begin
        add_ticks(int'(span(bus_cfg.reset_low_ticks)), 1'($urandom_range(0, 1)), odds);
        add_ticks(int'(span(bus_cfg.presence_wait_ticks)), ~bits[0], odds);
        add_ticks(int'(span(bus_cfg.reset_tail_ticks)), 1'($urandom_range(0, 1)), odds);
      end
      K_WRITE: begin
        for (int i = 0; i < 8; i++) begin
          b = d[i];
          add_ticks(int'(span(b ? bus_cfg.write_one_low_ticks : bus_cfg.write_zero_low_ticks)),
                    1'($urandom_range(0, 1)), odds);
          add_ticks(int'(span(b ? bus_cfg.write_one_high_ticks
                                : bus_cfg.write_zero_high_ticks)),
                    1'($urandom_range(0, 1)), odds);
        end
      end
      default: begin
        for (int i = 0; i < 8; i++) begin
          add_ticks(int'(span(bus_cfg.read_low_ticks)), 1'($urandom_range(0, 1)), odds);
          add_ticks(int'(span(owb_pkg::READ_SAMPLE_TICKS)), bits[i], odds);
          add_ticks(int'(span(owb_pkg::READ_TAIL_TICKS)), 1'($urandom_range(0, 1)), odds);
        end
      end
    endcase
  endtask

  task automatic commit(input int cut);
    owb_pkg::item_t junk;
    repeat (cut) junk = op_q.pop_back();
    while (op_q.size() != 0) cmd_q.push_back(op_q.pop_front());
  endtask

  // reset or write with random data; the last op of a batch may be cut short
  task automatic random_op(input int odds, input bit cut_ok);
    int         cut;
    logic [1:0] k;
    logic       clr;
    k = ($urandom_range(0, 9) < 4) ? K_RESET : K_WRITE;
    clr = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3))
        add_item(K_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    plan_op(k, 8'($urandom_range(0, 255)), clr, 8'($urandom_range(0, 255)), odds);
    cut = (cut_ok && $urandom_range(0, 1) == 0) ? $urandom_range(1, op_q.size() - 1) : 0;
    commit(cut);
  endtask

  // drain everything, then tick the block back to idle if a cut op left it busy
  task automatic settle();
    do begin
      while (cmd_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
      if (bus_phase != PH_IDLE) begin
        add_ticks(16, 1'b1, 0);
        commit(0);
      end
    end while (bus_phase != PH_IDLE || cmd_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input int idx, input logic [9:0] v,
                          output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= 5'(idx * 4);
    pwdata <= {22'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    for (int i = 0; i < R_COUNT; i++) begin
      apb_xfer(1'b0, i, 10'd0, rd);
      if (rd[9:0] !== get_reg(i)) begin
        errors++;
        if (errors <= 10)
          $display("register %0d readback: exp %0d got %0d", i, get_reg(i), rd[9:0]);
      end
    end
  endtask

  task automatic program_timing(input timing_e mode);
    logic [9:0]  v;
    logic [31:0] rd;
    for (int i = 0; i < R_COUNT; i++) begin
      case (mode)
        TM_MIN:   v = 10'd1;
        TM_ZERO:  v = 10'd0;
        TM_MAX:   v = CNT_TOP;
        TM_MIXED: v = $urandom_range(0, 1) ? CNT_TOP : 10'd1;
        default:  v = 10'($urandom_range(1, 6));
      endcase
      apb_xfer(1'b1, i, v, rd);
      put_reg(i, v);
    end
    check_regs();
    n_settings++;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // power-on register values, then ticks while idle
    check_regs();
    add_item(K_TICK, 8'hFF, 1'b0, 1'b1);
    add_item(K_TICK, 8'h00, 1'b1, 1'b0);
    commit(0);
    settle();

    // directed part on the shortest timing
    program_timing(TM_MIN);
    plan_op(K_RESET, 8'h00, 1'b0, 8'h01, 0);
    commit(0);
    plan_op(K_RESET, 8'hFF, 1'b1, 8'h00, 0);
    commit(0);
    plan_op(K_WRITE, 8'h00, 1'b1, 8'h00, 0);
    commit(0);
    plan_op(K_WRITE, 8'hFF, 1'b0, 8'h00, 0);
    commit(0);
    plan_op(K_WRITE, 8'h81, 1'b1, 8'h00, 4);
    commit(0);
    repeat (3) random_op(8, 1'b0);
    random_op(8, 1'b1);
    settle();

    program_timing(TM_ZERO);
    repeat (3) random_op(8, 1'b0);
    random_op(8, 1'b1);
    settle();

    // full-scale values by readback only
    program_timing(TM_MAX);
    program_timing(TM_SMALL);
    random_op(10, 1'b0);
    random_op(10, 1'b1);
    settle();

    calm = 1'b1;
    program_timing(TM_MIN);
    plan_op(K_READ, 8'h5A, 1'b1, 8'hA5, 60);
    commit(0);
    random_op(8, 1'b0);
    settle();
    repeat (10) @(posedge clk);

    errors += status_q.size();
    $display("%0d beats over %0d timing settings: %0d operations done, %0d commands refused",
             n_beats, n_settings + 1, n_done, n_refused);
    $display("%0d bytes read, %0d of them leaving a zero CRC residue", n_reads, n_good);
    if (errors == 0) begin
      $display("one_wire_bus_master_tb OK");
    end else begin
      $display("one_wire_bus_master_tb NOT OK");
    end
    $finish;
  end

endmodule

/* one_wire_bus_master.f */
sv/owb_pkg.sv
sv/owb_regs.sv
sv/owb_engine.sv
sv/one_wire_bus_master.sv
tb/one_wire_bus_master_tb.sv
